// File: design/pla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pla_pkg
// Shared types and constants of the priority lease arbiter: operation,
// response and release reason codes, and the lease timer widths.
// ----------------------------------------------------------------------------
package pla_pkg;

    // Lease timer and timeout register width.
    localparam int AGE_BITS = 16;
    localparam logic [AGE_BITS-1:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [AGE_BITS-1:0] AGE_MAX       = '1;

    // Field widths of the codes carried in tuser and tdata.
    localparam int OP_BITS     = 3;
    localparam int RESP_BITS   = 4;
    localparam int REASON_BITS = 3;

    // Operation carried by an input word.
    typedef enum logic [OP_BITS-1:0] {
        OP_ALARM_ON  = 3'd0,
        OP_ALARM_OFF = 3'd1,
        OP_START     = 3'd2,
        OP_STOP      = 3'd3,
        OP_KEEPALIVE = 3'd4,
        OP_TICK      = 3'd5
    } t_op;

    // Response carried by a result word.
    typedef enum logic [RESP_BITS-1:0] {
        RESP_NONE          = 4'd0,
        RESP_ALARM_CHANGED = 4'd1,
        RESP_GRANTED       = 4'd2,
        RESP_REFRESHED     = 4'd3,
        RESP_BUSY          = 4'd4,
        RESP_STOPPED       = 4'd5,
        RESP_STALE_STOP    = 4'd6,
        RESP_KEEPALIVE_OK  = 4'd7,
        RESP_KEEPALIVE_DROP = 4'd8,
        RESP_TICK_COUNTED  = 4'd9,
        RESP_TIMED_OUT     = 4'd10
    } t_resp;

    // Why a lease was released by the current word.
    typedef enum logic [REASON_BITS-1:0] {
        REASON_NONE     = 3'd0,
        REASON_PREEMPT  = 3'd1,
        REASON_TIMEOUT  = 3'd2,
        REASON_TAKEOVER = 3'd3,
        REASON_STOPPED  = 3'd4
    } t_reason;

endpackage

// File: design/priority_lease_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_lease_arbiter
// Exclusive-owner arbiter for one shared resource with a preempting alarm
// and an expiring lease. Every input word yields one result word.
// ----------------------------------------------------------------------------
// Result: a result word is registered in the output register, or in the skid
//   register while the output stalls, when its input word is accepted.
// Throughput: one word per cycle while the skid register is empty; the state
//   update and the result are one compare-and-count step, and a skid register
//   keeps intake going while one result waits.
// Reset: synchronous, active low; clears the alarm and the lease, empties the
//   output and skid registers, and sets the timeout to 3000 ticks.
// ----------------------------------------------------------------------------
module priority_lease_arbiter
    import pla_pkg::*;
#(
    parameter int SESSION_BITS = 32,
    parameter int OWNER_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration: lease_timeout_ticks.
    input  logic                  i_cfg_wr_en,
    input  logic [AGE_BITS-1:0]   i_cfg_wr_data,
    // Input stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata, lowest bit up: session, owner_id, takeover, zero fill.
    input  logic [((SESSION_BITS+OWNER_BITS+1+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: operation.
    input  logic [OP_BITS-1:0]    i_s_axis_tuser,
    // Result stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata, lowest bit up: release_reason, released_session, released_owner,
    // holder_session, holder_owner, lease_active, alarm_active, siren_wanted,
    // zero fill.
    output logic [((REASON_BITS+2*SESSION_BITS+2*OWNER_BITS+3+7)/8)*8-1:0]
                                  o_m_axis_tdata,
    // tuser: response.
    output logic [RESP_BITS-1:0]  o_m_axis_tuser
);

    localparam int OUT_FIELDS = REASON_BITS + 2*SESSION_BITS + 2*OWNER_BITS + 3;
    localparam int OUT_TW     = ((OUT_FIELDS + 7) / 8) * 8;

    // Arbiter state.
    logic                    r_alarm, n_alarm;
    logic                    r_lease, n_lease;
    logic [SESSION_BITS-1:0] r_sess,  n_sess;
    logic [OWNER_BITS-1:0]   r_owner, n_owner;
    logic [AGE_BITS-1:0]     r_age,   n_age;
    logic [AGE_BITS-1:0]     r_timeout;

    // Output and skid registers.
    logic                    r_out_valid;
    logic [OUT_TW-1:0]       r_out_data;
    logic [RESP_BITS-1:0]    r_out_user;
    logic                    r_skid_valid;
    logic [OUT_TW-1:0]       r_skid_data;
    logic [RESP_BITS-1:0]    r_skid_user;

    // Unpacked input word.
    t_op                     in_op;
    logic [SESSION_BITS-1:0] in_sess;
    logic [OWNER_BITS-1:0]   in_owner;
    logic                    in_take;

    // Result fields of the current word.
    t_resp                   res_resp;
    t_reason                 res_reason;
    logic [SESSION_BITS-1:0] res_rel_sess;
    logic [OWNER_BITS-1:0]   res_rel_owner;
    logic [OUT_TW-1:0]       res_data;

    logic in_fire;
    logic out_fire;
    logic sess_match;

    assign o_s_axis_tready = !r_skid_valid;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire        = r_out_valid && i_m_axis_tready;

    assign in_op    = t_op'(i_s_axis_tuser);
    assign in_sess  = i_s_axis_tdata[SESSION_BITS-1:0];
    assign in_owner = i_s_axis_tdata[SESSION_BITS +: OWNER_BITS];
    assign in_take  = i_s_axis_tdata[SESSION_BITS+OWNER_BITS];

    assign sess_match = r_lease && (in_sess == r_sess);

    // Next state and result for one input word.
    always_comb begin
        n_alarm       = r_alarm;
        n_lease       = r_lease;
        n_sess        = r_sess;
        n_owner       = r_owner;
        n_age         = r_age;
        res_resp      = RESP_NONE;
        res_reason    = REASON_NONE;
        res_rel_sess  = '0;
        res_rel_owner = '0;
        case (in_op)
            OP_ALARM_ON, OP_ALARM_OFF: begin
                if ((in_op == OP_ALARM_ON) != r_alarm) begin
                    n_alarm  = (in_op == OP_ALARM_ON);
                    res_resp = RESP_ALARM_CHANGED;
                    // A rising alarm preempts the lease.
                    if (in_op == OP_ALARM_ON && r_lease) begin
                        res_reason    = REASON_PREEMPT;
                        res_rel_sess  = r_sess;
                        res_rel_owner = r_owner;
                        n_lease       = 1'b0;
                        n_sess        = '0;
                        n_owner       = '0;
                        n_age         = '0;
                    end
                end
            end
            OP_START: begin
                if (sess_match) begin
                    n_age    = '0;
                    res_resp = RESP_REFRESHED;
                end else if (r_lease && !in_take) begin
                    res_resp = RESP_BUSY;
                end else begin
                    if (r_lease) begin
                        res_reason    = REASON_TAKEOVER;
                        res_rel_sess  = r_sess;
                        res_rel_owner = r_owner;
                    end
                    n_lease  = 1'b1;
                    n_sess   = in_sess;
                    n_owner  = in_owner;
                    n_age    = '0;
                    res_resp = RESP_GRANTED;
                end
            end
            OP_STOP: begin
                if (r_lease) begin
                    if (!sess_match) begin
                        res_resp = RESP_STALE_STOP;
                    end else begin
                        res_reason    = REASON_STOPPED;
                        res_rel_sess  = r_sess;
                        res_rel_owner = r_owner;
                        n_lease       = 1'b0;
                        n_sess        = '0;
                        n_owner       = '0;
                        n_age         = '0;
                        res_resp      = RESP_STOPPED;
                    end
                end
            end
            OP_KEEPALIVE: begin
                if (sess_match) begin
                    n_age    = '0;
                    res_resp = RESP_KEEPALIVE_OK;
                end else begin
                    res_resp = RESP_KEEPALIVE_DROP;
                end
            end
            OP_TICK: begin
                if (r_lease) begin
                    if (r_age >= r_timeout) begin
                        res_reason    = REASON_TIMEOUT;
                        res_rel_sess  = r_sess;
                        res_rel_owner = r_owner;
                        n_lease       = 1'b0;
                        n_sess        = '0;
                        n_owner       = '0;
                        n_age         = '0;
                        res_resp      = RESP_TIMED_OUT;
                    end else begin
                        if (r_age != AGE_MAX) begin
                            n_age = r_age + 1'b1;
                        end
                        res_resp = RESP_TICK_COUNTED;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Pack the result word; holder fields are zero whenever no lease is held,
    // since a released lease clears its session and owner.
    assign res_data = OUT_TW'({(n_alarm && !n_lease), n_alarm, n_lease,
                               n_owner, n_sess, res_rel_owner, res_rel_sess,
                               res_reason});

    // Arbiter state and timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm   <= 1'b0;
            r_lease   <= 1'b0;
            r_sess    <= '0;
            r_owner   <= '0;
            r_age     <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_alarm <= n_alarm;
                r_lease <= n_lease;
                r_sess  <= n_sess;
                r_owner <= n_owner;
                r_age   <= n_age;
            end
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_data   <= r_skid_data;
                r_out_user   <= r_skid_user;
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
                r_out_data  <= res_data;
                r_out_user  <= res_resp;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= res_data;
                r_skid_user  <= res_resp;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // The skid register only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a word while the output is empty");

    // The skid register fills only when a word arrives into a stalled output.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(in_fire && r_out_valid && !out_fire))
        else $error("skid register filled without a stalled output");

    // An idle holder carries zero session and owner.
    a_idle_holder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_lease |-> (r_sess == '0 && r_owner == '0 && r_age == '0))
        else $error("lease fields not cleared while no lease is held");

    // A released lease is reported only with a reason.
    a_release_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && res_reason == REASON_NONE) |->
            (res_rel_sess == '0 && res_rel_owner == '0))
        else $error("released lease reported without a reason");

endmodule
